/* rtl/sfdd_pkg.sv */
// Package for the scrolling four-digit display controller.
// Holds command and mode codes, character constants, the output beat type
// and the glyph helper functions. Depends on nothing.
package sfdd_pkg;

	// Command codes (input tuser)
	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_MODE      = 3'd1;
	localparam logic [2:0] OP_STR_START = 3'd2;
	localparam logic [2:0] OP_STR_CHAR  = 3'd3;
	localparam logic [2:0] OP_HEX       = 3'd4;

	// Display modes
	localparam logic [2:0] MODE_OFF    = 3'd0;
	localparam logic [2:0] MODE_RUN    = 3'd1;
	localparam logic [2:0] MODE_ANIM   = 3'd2;
	localparam logic [2:0] MODE_STATIC = 3'd3;
	localparam logic [2:0] MODE_SCROLL = 3'd4;
	localparam logic [2:0] MODE_ONCE   = 3'd5;

	// Constant beat sources
	localparam logic [1:0] KIND_OFF  = 2'd0;
	localparam logic [1:0] KIND_RUN  = 2'd1;
	localparam logic [1:0] KIND_ANIM = 2'd2;

	// Character codes
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_BIT   = 8'h20;
	localparam logic [6:0] GL_SPACE   = 7'h20;
	localparam logic [6:0] GL_NULL    = 7'h00;
	localparam logic [6:0] GL_DASH    = 7'h2D;
	localparam logic [6:0] GL_BSLASH  = 7'h5C;
	localparam logic [6:0] GL_ONE     = 7'h31;
	localparam logic [6:0] GL_SLASH   = 7'h2F;
	localparam logic [6:0] GL_R       = 7'h52;
	localparam logic [6:0] GL_U       = 7'h55;
	localparam logic [6:0] GL_N       = 7'h4E;

	localparam logic [3:0] HEX_TEN    = 4'hA;
	localparam logic [7:0] HEX_NUM0   = 8'h30;
	localparam logic [7:0] HEX_ALPHA  = 8'h37;

	localparam logic [1:0] LAST_DIGIT = 2'd3;
	localparam logic [2:0] NUM_DIGITS = 3'd4;

	// Output queue
	localparam int OFIFO_DEPTH = 8;
	localparam int OFIFO_PW    = 3;
	localparam logic [OFIFO_PW:0] OFIFO_ROOM = 4'd5;

	// One digit write
	typedef struct packed {
		logic [1:0] digit;
		logic [6:0] glyph;
		logic       last;
	} beat_t;

	// Fold lowercase to uppercase, keep seven bits
	function automatic logic [6:0] fold_glyph(input logic [7:0] ch);
		logic [7:0] c;
		c = ch;
		if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
			c = ch & ~CASE_BIT;
		return c[6:0];
	endfunction

	// One uppercase hex digit
	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < HEX_TEN)
			r = HEX_NUM0 + {4'd0, v};
		else
			r = HEX_ALPHA + {4'd0, v};
		return r;
	endfunction

	// Spinner glyph from timer bits 4:3
	function automatic logic [6:0] anim_glyph(input logic [4:0] tc);
		logic [6:0] g;
		case (tc[4:3])
			2'd0:    g = GL_DASH;
			2'd1:    g = GL_BSLASH;
			2'd2:    g = GL_ONE;
			default: g = GL_SLASH;
		endcase
		return g;
	endfunction

	// Beats that do not come from the text store
	function automatic beat_t const_beat(input logic [1:0] kind, input logic [2:0] step,
			input logic [4:0] tc);
		beat_t b;
		b.digit = step[1:0];
		b.glyph = GL_SPACE;
		b.last  = 1'b0;
		case (kind)
			KIND_RUN: begin
				case (step)
					3'd0:    b.glyph = GL_R;
					3'd1:    b.glyph = GL_U;
					3'd2:    b.glyph = GL_N;
					3'd3:    b.glyph = GL_DASH;
					default: begin
						b.digit = LAST_DIGIT;
						b.glyph = anim_glyph(tc);
						b.last  = 1'b1;
					end
				endcase
			end
			KIND_ANIM: begin
				b.digit = LAST_DIGIT;
				b.glyph = anim_glyph(tc);
				b.last  = 1'b1;
			end
			default: begin
				if (step[1:0] == LAST_DIGIT) begin
					b.glyph = GL_NULL;
					b.last  = 1'b1;
				end
			end
		endcase
		return b;
	endfunction

endpackage

/* rtl/sfdd_mem.sv */
// Text store: single-port synchronous RAM with a registered read.
// Per-entry valid flops make unwritten entries read as zero after reset.
// Depends on nothing.
module sfdd_mem #(
	parameter int TEXT_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic                          re,
	input  logic [$clog2(TEXT_DEPTH)-1:0] addr,
	input  logic [7:0]                    wdata,
	output logic [7:0]                    rdata
);
	logic [7:0]            mem_q [TEXT_DEPTH];
	logic [7:0]            rd_s1;
	logic                  rd_vld_s1;
	logic [TEXT_DEPTH-1:0] valid_q;

	// RAM array and read register
	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		if (re)
			rd_s1 <= mem_q[addr];
	end

	// Written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (we)
				valid_q[addr] <= 1'b1;
			if (re)
				rd_vld_s1 <= valid_q[addr];
		end
	end

	assign rdata = rd_vld_s1 ? rd_s1 : 8'd0;

endmodule

/* rtl/sfdd_ofifo.sv */
// Output queue of digit-write beats between sequencer and master port.
// Depends on sfdd_pkg.
module sfdd_ofifo
	import sfdd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  beat_t             push_beat,
	input  logic              pop,
	output logic              out_valid,
	output beat_t             out_beat,
	output logic [OFIFO_PW:0] free
);
	beat_t                fifo_q [OFIFO_DEPTH];
	logic [OFIFO_PW-1:0]  wptr_q;
	logic [OFIFO_PW-1:0]  rptr_q;
	logic [OFIFO_PW:0]    count_q;
	logic                 do_pop;

	assign out_valid = (count_q != '0);
	assign out_beat  = fifo_q[rptr_q];
	assign do_pop    = pop && out_valid;
	assign free      = (OFIFO_PW+1)'(OFIFO_DEPTH) - count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wptr_q] <= push_beat;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= rptr_q + 1'b1;
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/sfdd_seq.sv */
// Command sequencer: holds mode, timer, length, offset and fill index, and
// runs read and write sequences on the text store. Depends on sfdd_pkg.
module sfdd_seq
	import sfdd_pkg::*;
#(
	parameter int TEXT_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    op,
	input  logic [2:0]                    new_mode,
	input  logic                          append,
	input  logic [7:0]                    text_char,
	input  logic [7:0]                    hex_value,
	output logic                          mem_we,
	output logic                          mem_re,
	output logic [$clog2(TEXT_DEPTH)-1:0] mem_addr,
	output logic [7:0]                    mem_wdata,
	input  logic [7:0]                    mem_rdata,
	input  logic [OFIFO_PW:0]             fifo_free,
	output logic                          push,
	output beat_t                         push_beat
);
	localparam int IW = $clog2(TEXT_DEPTH);
	localparam int AW = IW + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EMIT  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_WRITE = 2'd3;

	logic [1:0]    state_q;
	logic [2:0]    mode_q;
	logic [4:0]    tick_q;
	logic [IW-1:0] len_q;
	logic [IW-1:0] off_q;
	logic [IW-1:0] fill_q;
	logic [2:0]    step_q;
	logic [1:0]    kind_q;
	logic [IW-1:0] base_q;
	logic [IW-1:0] wr_addr_q;
	logic [7:0]    wr_data_q;
	logic [1:0]    wr_left_q;
	logic          rd_pend_s1;
	logic          rd_oor_s1;
	logic [1:0]    rd_digit_s1;

	logic          accept;
	logic [4:0]    tc_next;
	logic [IW-1:0] start_fi;
	logic          char_ok;
	logic [IW-1:0] hex_pos;
	logic          hex_ok;
	logic [AW-1:0] hex_end;
	logic [IW-1:0] hex_len;
	logic          scroll_go;
	logic          scroll_adv;
	logic [AW-1:0] rd_addr_ext;
	logic          rd_in_range;
	logic          rd_issue;
	beat_t         emit_beat;

	assign in_ready = (state_q == ST_IDLE) && (fifo_free >= OFIFO_ROOM);
	assign accept   = in_valid && in_ready;
	assign tc_next  = tick_q + 5'd1;

	// Command decode helpers
	assign start_fi   = append ? len_q : '0;
	assign char_ok    = (text_char != 8'd0) && (fill_q < IW'(TEXT_DEPTH - 1));
	assign hex_pos    = append ? len_q : '0;
	assign hex_ok     = ({1'b0, hex_pos} + AW'(3)) < AW'(TEXT_DEPTH);
	assign hex_end    = {1'b0, hex_pos} + AW'(2);
	assign hex_len    = (hex_end > AW'(TEXT_DEPTH - 1)) ? IW'(TEXT_DEPTH - 1) : hex_end[IW-1:0];
	assign scroll_go  = (len_q != '0) && (tc_next == 5'd0);
	assign scroll_adv = ({1'b0, off_q} + AW'(3)) <= {1'b0, len_q};

	// Read address for the current digit
	assign rd_addr_ext = {1'b0, base_q} + AW'(step_q);
	assign rd_in_range = rd_addr_ext < AW'(TEXT_DEPTH);
	assign rd_issue    = (state_q == ST_READ) && (step_q < NUM_DIGITS);
	assign emit_beat   = const_beat(kind_q, step_q, tick_q);

	// Store port
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = '0;
		mem_wdata = 8'd0;
		if (accept) begin
			case (op)
				OP_STR_START: begin
					mem_we    = 1'b1;
					mem_addr  = start_fi;
					mem_wdata = CH_SPACE;
				end
				OP_STR_CHAR: begin
					mem_we    = char_ok;
					mem_addr  = fill_q;
					mem_wdata = text_char;
				end
				OP_HEX: begin
					mem_we    = hex_ok;
					mem_addr  = hex_pos;
					mem_wdata = hex_digit(hex_value[7:4]);
				end
				default: ;
			endcase
		end else if (state_q == ST_WRITE) begin
			mem_we    = 1'b1;
			mem_addr  = wr_addr_q;
			mem_wdata = wr_data_q;
		end else if (rd_issue) begin
			mem_re   = rd_in_range;
			mem_addr = rd_addr_ext[IW-1:0];
		end
	end

	// Beat toward the output queue
	always_comb begin
		push      = 1'b0;
		push_beat = emit_beat;
		if (state_q == ST_EMIT) begin
			push = 1'b1;
		end else if (rd_pend_s1) begin
			push            = 1'b1;
			push_beat.digit = rd_digit_s1;
			push_beat.glyph = rd_oor_s1 ? GL_NULL : fold_glyph(mem_rdata);
			push_beat.last  = (rd_digit_s1 == LAST_DIGIT);
		end
	end

	// Read pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_oor_s1   <= !rd_in_range;
		rd_digit_s1 <= step_q[1:0];
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= MODE_OFF;
			tick_q    <= '0;
			len_q     <= '0;
			off_q     <= '0;
			fill_q    <= '0;
			step_q    <= '0;
			kind_q    <= KIND_OFF;
			base_q    <= '0;
			wr_addr_q <= '0;
			wr_data_q <= '0;
			wr_left_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						case (op)
							OP_TICK: begin
								tick_q <= tc_next;
								case (mode_q) inside
									MODE_RUN: begin
										kind_q  <= KIND_RUN;
										state_q <= ST_EMIT;
										mode_q  <= MODE_ANIM;
									end
									MODE_ANIM: begin
										kind_q  <= KIND_ANIM;
										state_q <= ST_EMIT;
									end
									MODE_STATIC: begin
										base_q  <= '0;
										state_q <= ST_READ;
									end
									MODE_SCROLL, MODE_ONCE: begin
										if (scroll_go) begin
											base_q  <= off_q;
											state_q <= ST_READ;
											if (scroll_adv) begin
												off_q <= off_q + 1'b1;
											end else begin
												off_q <= '0;
												if (mode_q == MODE_ONCE)
													mode_q <= MODE_RUN;
											end
										end
									end
									default: begin
										kind_q  <= KIND_OFF;
										state_q <= ST_EMIT;
									end
								endcase
							end
							OP_MODE: begin
								mode_q <= new_mode;
							end
							OP_STR_START: begin
								fill_q <= start_fi;
								len_q  <= start_fi;
								off_q  <= '0;
							end
							OP_STR_CHAR: begin
								if (char_ok) begin
									fill_q    <= fill_q + 1'b1;
									len_q     <= fill_q + 1'b1;
									off_q     <= '0;
									wr_addr_q <= fill_q + 1'b1;
									wr_data_q <= CH_SPACE;
									wr_left_q <= 2'd1;
									state_q   <= ST_WRITE;
								end
							end
							OP_HEX: begin
								len_q <= hex_len;
								off_q <= '0;
								if (hex_ok) begin
									wr_addr_q <= hex_pos + 1'b1;
									wr_data_q <= hex_digit(hex_value[3:0]);
									wr_left_q <= 2'd2;
									state_q   <= ST_WRITE;
								end
							end
							default: ;
						endcase
					end
				end
				ST_EMIT: begin
					step_q <= step_q + 1'b1;
					if (emit_beat.last)
						state_q <= ST_IDLE;
				end
				ST_READ: begin
					step_q <= step_q + 1'b1;
					if (step_q == NUM_DIGITS)
						state_q <= ST_IDLE;
				end
				ST_WRITE: begin
					wr_addr_q <= wr_addr_q + 1'b1;
					wr_data_q <= CH_SPACE;
					wr_left_q <= wr_left_q - 1'b1;
					if (wr_left_q == 2'd1)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/scrolling_four_digit_display_controller_top.sv */
// Top level of the scrolling four-digit display controller.
// Depends on sfdd_pkg, sfdd_mem, sfdd_ofifo and sfdd_seq.
//
// Channel   Dir  Accept at edge with      Contents
// s_axis    in   tvalid & tready          command beat (op in tuser)
// m_axis    out  tvalid & tready          digit-write beat (last in tlast)
//
// A string character writes the character and a trailing space to the
// text store, a hex byte two digits and a space. A tick writes one beat per
// constant write (off 4, run 5, animation 1), or four for static and scroll
// text from four registered store reads; a scroll tick with nothing to show
// writes nothing. Writes queue in an 8-beat output FIFO: the next command is
// taken while earlier writes wait, as long as five slots are free.
// Reset is asynchronous; the text store reads as zero until written.
module scrolling_four_digit_display_controller_top
	import sfdd_pkg::*;
#(
	parameter int TEXT_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // new_mode[2:0], append[3], text_char[11:4],
	                                   // hex_value[19:12], zero[23:20]
	input  logic [2:0]  s_axis_tuser,  // op[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // digit[1:0], glyph[8:2], zero[15:9]
	output logic        m_axis_tlast   // last
);
	localparam int IW = $clog2(TEXT_DEPTH);

	logic              mem_we;
	logic              mem_re;
	logic [IW-1:0]     mem_addr;
	logic [7:0]        mem_wdata;
	logic [7:0]        mem_rdata;
	logic              push;
	beat_t             push_beat;
	beat_t             out_beat;
	logic [OFIFO_PW:0] fifo_free;

	sfdd_seq #(
		.TEXT_DEPTH(TEXT_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.op        (s_axis_tuser),
		.new_mode  (s_axis_tdata[2:0]),
		.append    (s_axis_tdata[3]),
		.text_char (s_axis_tdata[11:4]),
		.hex_value (s_axis_tdata[19:12]),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.fifo_free (fifo_free),
		.push      (push),
		.push_beat (push_beat)
	);

	sfdd_mem #(
		.TEXT_DEPTH(TEXT_DEPTH)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.re     (mem_re),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	sfdd_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_beat (push_beat),
		.pop       (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_beat  (out_beat),
		.free      (fifo_free)
	);

	// Output beat packing
	assign m_axis_tdata = {7'd0, out_beat.glyph, out_beat.digit};
	assign m_axis_tlast = out_beat.last;

endmodule

/* rtl/sfdd_checker.sv */
// Port-level checks for the display controller, bound to the top level.
// Depends on sfdd_pkg and scrolling_four_digit_display_controller_top.
module sfdd_checker
	import sfdd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	// Every tick's final write lands on the rightmost digit
	a_last_on_digit3: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[1:0] == LAST_DIGIT))
		else $error("final write not on rightmost digit");

	// A non-final write to the rightmost digit only comes from the run banner
	a_banner_dash: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast && m_axis_tdata[1:0] == LAST_DIGIT)
		|-> (m_axis_tdata[8:2] == GL_DASH))
		else $error("unexpected non-final write on rightmost digit");

	// Pad bits of the output beat stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:9] == 7'd0))
		else $error("output pad bits set");

	// A stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("stalled output beat changed");

endmodule

bind scrolling_four_digit_display_controller_top sfdd_checker u_sfdd_checker (.*);

/* verif/scrolling_four_digit_display_controller_top_tb.sv */
// Self-checking testbench for scrolling_four_digit_display_controller_top.
// Drives command beats from a directed table and then random command sequences, predicts
// every digit write in-line and checks them in order. Depends on sfdd_pkg and the RTL.
`timescale 1ns / 1ps

module scrolling_four_digit_display_controller_top_tb;
	import sfdd_pkg::*;

	localparam int STORE_DEPTH = 32;
	localparam int DIR_COUNT = 26;
	localparam int RAND_COUNT = 144;

	// Codes outside the defined sets
	localparam logic [2:0] OP_SPARE_LO  = 3'd5;
	localparam logic [2:0] OP_SPARE_HI  = 3'd7;
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	// Spinner and run banner characters
	localparam logic [7:0] SPIN_CH [4] = '{8'h2D, 8'h5C, 8'h31, 8'h2F};
	localparam logic [7:0] RUN_CH  [4] = '{8'h52, 8'h55, 8'h4E, 8'h2D};

	// One directed row; blank_tick marks a tick whose writes are typed in (display off)
	typedef struct packed {
		logic [2:0] op;
		logic [2:0] mode;
		logic       app;
		logic [7:0] ch;
		logic [7:0] hv;
		logic       blank_tick;
	} cmd_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // new_mode[2:0], append[3], text_char[11:4],
	                            // hex_value[19:12], zero[23:20]
	logic [2:0]  s_axis_tuser;  // op[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;  // digit[1:0], glyph[8:2], zero[15:9]
	logic        m_axis_tlast;  // last

	// Predicted display state
	logic [2:0] disp_mode;
	logic [4:0] timer;
	logic [7:0] text_mem [STORE_DEPTH];
	int         text_len;
	int         scroll_pos;
	int         fill_pos;

	beat_t expected_writes [$];
	int    mismatches = 0;
	logic  calm;

	cmd_row_t dir_rows [DIR_COUNT] = '{
		'{OP_TICK,      MODE_OFF,      1'b0, 8'h00, 8'h00, 1'b1},
		'{OP_SPARE_LO,  MODE_OFF,      1'b0, 8'h00, 8'h00, 1'b0},
		'{OP_SPARE_HI,  MODE_OFF,      1'b0, 8'h00, 8'h00, 1'b0},
		'{OP_MODE,      MODE_SPARE_LO, 1'b0, 8'h00, 8'h00, 1'b0},
		'{OP_TICK,      MODE_OFF,      1'b0, 8'h00, 8'h00, 1'b1},
		'{OP_MODE,      MODE_SPARE_HI, 1'b0, 8'h00, 8'h00, 1'b0},
		'{OP_TICK,      MODE_OFF,      1'b0, 8'h00, 8'h00, 1'b1},
		'{OP_STR_START, MODE_OFF,      1'b0, 8'h00, 8'h00, 1'b0},
		'{OP_STR_CHAR,  MODE_OFF,      1'b0, 8'h61, 8'h00, 1'b0},
		'{OP_STR_CHAR,  MODE_OFF,      1'b0, 8'h7A, 8'h00, 1'b0},
		'{OP_STR_CHAR,  MODE_OFF,      1'b0, 8'h00, 8'h00, 1'b0},
		'{OP_STR_CHAR,  MODE_OFF,      1'b0, 8'hFF, 8'h00, 1'b0},
		'{OP_STR_CHAR,  MODE_OFF,      1'b0, 8'h60, 8'h00, 1'b0},
		'{OP_STR_CHAR,  MODE_OFF,      1'b0, 8'h7B, 8'h00, 1'b0},
		'{OP_HEX,       MODE_OFF,      1'b1, 8'h00, 8'h00, 1'b0},
		'{OP_HEX,       MODE_OFF,      1'b1, 8'h00, 8'hFF, 1'b0},
		'{OP_MODE,      MODE_STATIC,   1'b0, 8'h00, 8'h00, 1'b0},
		'{OP_TICK,      MODE_OFF,      1'b0, 8'h00, 8'h00, 1'b0},
		'{OP_MODE,      MODE_RUN,      1'b0, 8'h00, 8'h00, 1'b0},
		'{OP_TICK,      MODE_OFF,      1'b0, 8'h00, 8'h00, 1'b0},
		'{OP_TICK,      MODE_OFF,      1'b0, 8'h00, 8'h00, 1'b0},
		'{OP_HEX,       MODE_OFF,      1'b0, 8'h00, 8'h9A, 1'b0},
		'{OP_STR_START, MODE_OFF,      1'b1, 8'h00, 8'h00, 1'b0},
		'{OP_STR_CHAR,  MODE_OFF,      1'b0, 8'h01, 8'h00, 1'b0},
		'{OP_MODE,      MODE_SCROLL,   1'b0, 8'h00, 8'h00, 1'b0},
		'{OP_MODE,      MODE_ONCE,     1'b0, 8'h00, 8'h00, 1'b0}
	};

	scrolling_four_digit_display_controller_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Store read; past the end reads as zero
	function automatic logic [7:0] text_at(input int idx);
		if (idx >= STORE_DEPTH)
			return 8'h00;
		return text_mem[idx];
	endfunction

	function automatic void text_put(input int idx, input logic [7:0] v);
		if (idx < STORE_DEPTH)
			text_mem[idx] = v;
	endfunction

	// One digit write, lowercase folded to uppercase
	function automatic beat_t digit_write(input int pos, input logic [7:0] ch);
		beat_t b;
		logic [7:0] c;
		c = ch;
		if (c >= 8'h61 && c <= 8'h7A)
			c[5] = 1'b0;
		b.digit = pos[1:0];
		b.glyph = c[6:0];
		b.last  = 1'b0;
		return b;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + {4'd0, v};
		return 8'h41 + {4'd0, v} - 8'd10;
	endfunction

	// Advance the display state by one command; returns the number of digit writes
	function automatic int predict_display(input logic [2:0] op, input logic [2:0] mode,
			input logic app, input logic [7:0] ch, input logic [7:0] hv,
			output beat_t res [5]);
		int n;
		int pos;
		n = 0;
		case (op)
			OP_TICK: begin
				timer = timer + 5'd1;
				case (disp_mode)
					MODE_RUN: begin
						for (int i = 0; i < 4; i++)
							res[n++] = digit_write(i, RUN_CH[i]);
						disp_mode = MODE_ANIM;
						res[n++] = digit_write(3, SPIN_CH[timer[4:3]]);
					end
					MODE_ANIM: res[n++] = digit_write(3, SPIN_CH[timer[4:3]]);
					MODE_STATIC: begin
						for (int i = 0; i < 4; i++)
							res[n++] = digit_write(i, text_at(i));
					end
					MODE_SCROLL, MODE_ONCE: begin
						if (text_len != 0 && timer == 5'd0) begin
							for (int i = 0; i < 4; i++)
								res[n++] = digit_write(i, text_at(scroll_pos + i));
							if (scroll_pos + 3 <= text_len) begin
								scroll_pos++;
							end else begin
								scroll_pos = 0;
								if (disp_mode == MODE_ONCE)
									disp_mode = MODE_RUN;
							end
						end
					end
					default: begin
						// off and the spare mode codes
						for (int i = 0; i < 3; i++)
							res[n++] = digit_write(i, CH_SPACE);
						res[n++] = digit_write(3, 8'h00);
					end
				endcase
				if (n > 0)
					res[n - 1].last = 1'b1;
			end
			OP_MODE: disp_mode = mode;
			OP_STR_START: begin
				fill_pos = app ? text_len : 0;
				text_put(fill_pos, CH_SPACE);
				text_len   = fill_pos;
				scroll_pos = 0;
			end
			OP_STR_CHAR: begin
				// code 0 is ignored, a full store drops the character
				if (ch != 8'h00 && fill_pos < STORE_DEPTH - 1) begin
					text_put(fill_pos, ch);
					fill_pos++;
					text_put(fill_pos, CH_SPACE);
					text_len   = fill_pos;
					scroll_pos = 0;
				end
			end
			OP_HEX: begin
				pos = app ? text_len : 0;
				if (pos < STORE_DEPTH - 3) begin
					text_put(pos, hex_char(hv[7:4]));
					text_put(pos + 1, hex_char(hv[3:0]));
					text_put(pos + 2, CH_SPACE);
				end
				pos += 2;
				if (pos > STORE_DEPTH - 1)
					pos = STORE_DEPTH - 1;
				text_len   = pos;
				scroll_pos = 0;
			end
			default: ;
		endcase
		return n;
	endfunction

	// Drive one command beat, wait for the handshake, then queue what it should write
	task automatic send_command(input logic [2:0] op, input logic [2:0] mode, input logic app,
			input logic [7:0] ch, input logic [7:0] hv, input logic blank_tick);
		beat_t res [5];
		beat_t b;
		int n;
		while (!calm && $urandom_range(99) < 30) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'd0, hv, ch, app, mode};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		n = predict_display(op, mode, app, ch, hv, res);
		if (blank_tick) begin
			// display off: three spaces, then a blank code on the rightmost digit
			for (int i = 0; i < 4; i++) begin
				b.digit = i[1:0];
				b.glyph = (i == 3) ? GL_NULL : GL_SPACE;
				b.last  = (i == 3);
				expected_writes.push_back(b);
			end
		end else begin
			for (int i = 0; i < n; i++)
				expected_writes.push_back(res[i]);
		end
	endtask

	// Output side: random stalls, none during the calm stretch
	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 30);

	// Check each digit-write beat against the oldest expectation
	always @(posedge clk) begin
		beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_writes.size() == 0) begin
				$error("unexpected beat: digit %0d glyph 0x%02h last %0d",
					m_axis_tdata[1:0], m_axis_tdata[8:2], m_axis_tlast);
				mismatches++;
			end else begin
				want = expected_writes.pop_front();
				if (m_axis_tdata[1:0] !== want.digit) begin
					$error("digit: expected %0d, got %0d", want.digit, m_axis_tdata[1:0]);
					mismatches++;
				end
				if (m_axis_tdata[8:2] !== want.glyph) begin
					$error("glyph: expected 0x%02h, got 0x%02h", want.glyph, m_axis_tdata[8:2]);
					mismatches++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		int counted;
		int pick;
		int nchar;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_TICK;
		calm          = 1'b0;
		disp_mode     = MODE_OFF;
		timer         = 5'd0;
		text_len      = 0;
		scroll_pos    = 0;
		fill_pos      = 0;
		for (int i = 0; i < STORE_DEPTH; i++)
			text_mem[i] = 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int r = 0; r < DIR_COUNT; r++)
			send_command(dir_rows[r].op, dir_rows[r].mode, dir_rows[r].app,
				dir_rows[r].ch, dir_rows[r].hv, dir_rows[r].blank_tick);

		// Random command sequences
		counted = 0;
		while (counted < RAND_COUNT) begin
			calm = (counted >= 50 && counted < 100);
			pick = $urandom_range(99);
			if (pick < 20) begin
				// string load: mostly short, sometimes long enough to truncate
				pick = $urandom_range(99);
				if (pick < 50)
					nchar = $urandom_range(4);
				else if (pick < 85)
					nchar = $urandom_range(12, 5);
				else
					nchar = $urandom_range(34, 28);
				send_command(OP_STR_START, 3'($urandom_range(7)), 1'($urandom_range(1)),
					8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
				counted++;
				for (int i = 0; i < nchar; i++) begin
					send_command(OP_STR_CHAR, 3'($urandom_range(7)), 1'($urandom_range(1)),
						($urandom_range(49) == 0) ? 8'h00 : 8'($urandom_range(255, 1)),
						8'($urandom_range(255)), 1'b0);
					counted++;
				end
				if (nchar >= 28 && $urandom_range(1)) begin
					// hex after a nearly full store: nothing stored from length 29, length saturates from 30
					send_command(OP_HEX, 3'($urandom_range(7)), 1'b1,
						8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
					counted++;
				end
			end else if (pick < 30) begin
				nchar = $urandom_range(3, 1);
				for (int i = 0; i < nchar; i++) begin
					send_command(OP_HEX, 3'($urandom_range(7)), 1'($urandom_range(1)),
						8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
					counted++;
				end
			end else if (pick < 45) begin
				send_command(OP_MODE, 3'($urandom_range(7)), 1'($urandom_range(1)),
					8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
				counted++;
			end else if (pick < 55) begin
				// noise: spare op codes, no effect
				send_command(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)),
					3'($urandom_range(7)), 1'($urandom_range(1)),
					8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
				counted++;
			end else begin
				// tick burst; scroll modes only write once per timer wrap
				if (disp_mode == MODE_SCROLL || disp_mode == MODE_ONCE)
					nchar = $urandom_range(100, 20);
				else
					nchar = $urandom_range(8, 1);
				if (nchar > RAND_COUNT - counted)
					nchar = RAND_COUNT - counted;
				for (int i = 0; i < nchar; i++) begin
					send_command(OP_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)),
						8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
					counted++;
				end
			end
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;

		// Drain, then allow for any stray writes
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
rtl/sfdd_pkg.sv
rtl/sfdd_mem.sv
rtl/sfdd_ofifo.sv
rtl/sfdd_seq.sv
rtl/scrolling_four_digit_display_controller_top.sv
rtl/sfdd_checker.sv
verif/scrolling_four_digit_display_controller_top_tb.sv
